// ===== hw/rtl/afc_pkg.sv =====
// Shared types and constants for the addressed frame checker.
package afc_pkg;

    // Framing bytes.
    localparam logic [7:0] START_BYTE = 8'hF7;
    localparam logic [7:0] END_BYTE   = 8'h7F;

    // Configuration register indexes.
    localparam logic CFG_SOURCE = 1'b0;
    localparam logic CFG_OWN    = 1'b1;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_CMD    = 2'd0,
        KIND_PARAM  = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    // Final status codes.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_CHECKSUM = 3'd1,
        ST_SOURCE   = 3'd2,
        ST_DEST     = 3'd3,
        ST_TERM     = 3'd4,
        ST_SHORT    = 3'd5
    } t_status;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_SRC  = 3'd1,
        PH_DST  = 3'd2,
        PH_CLEN = 3'd3,
        PH_PLEN = 3'd4,
        PH_BODY = 3'd5,
        PH_TERM = 3'd6,
        PH_DONE = 3'd7
    } t_phase;

    // One result item.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        t_status    status;
        logic       frame_done;
    } t_result;

endpackage

// ===== hw/rtl/afc_parser.sv =====
// Frame parser: per-byte phase tracking, checks and result generation.
module afc_parser
    import afc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    input  logic       i_buffer_start,
    input  logic [7:0] i_accepted_source,
    input  logic [7:0] i_own_address,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_clen, n_clen;
    logic [7:0] r_plen, n_plen;
    logic [7:0] r_ccnt, n_ccnt;
    logic [7:0] r_pcnt, n_pcnt;
    logic [7:0] r_sum, n_sum;

    // State as seen by this byte: a buffer start clears it first.
    t_phase     cur_phase;
    logic [7:0] cur_clen, cur_plen, cur_ccnt, cur_pcnt, cur_sum;
    logic       cmd_left, param_left;

    assign cur_phase  = i_buffer_start ? PH_HUNT : r_phase;
    assign cur_clen   = i_buffer_start ? 8'd0 : r_clen;
    assign cur_plen   = i_buffer_start ? 8'd0 : r_plen;
    assign cur_ccnt   = i_buffer_start ? 8'd0 : r_ccnt;
    assign cur_pcnt   = i_buffer_start ? 8'd0 : r_pcnt;
    assign cur_sum    = i_buffer_start ? 8'd0 : r_sum;
    assign cmd_left   = cur_ccnt < cur_clen;
    assign param_left = cur_pcnt < cur_plen;

    // Next state of the phase and the frame counters.
    always_comb begin
        n_phase = r_phase;
        n_clen  = r_clen;
        n_plen  = r_plen;
        n_ccnt  = r_ccnt;
        n_pcnt  = r_pcnt;
        n_sum   = r_sum;
        if (i_valid) begin
            n_phase = cur_phase;
            n_clen  = cur_clen;
            n_plen  = cur_plen;
            n_ccnt  = cur_ccnt;
            n_pcnt  = cur_pcnt;
            n_sum   = cur_sum;
            if (cur_phase == PH_DONE) begin
                n_phase = PH_DONE;
            end else if (i_rx_byte == 8'd0) begin
                n_phase = PH_DONE;
            end else begin
                case (cur_phase)
                    PH_HUNT: begin
                        if (i_rx_byte == START_BYTE) begin
                            n_phase = PH_SRC;
                        end
                    end
                    PH_SRC: begin
                        if (i_rx_byte != i_accepted_source) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_sum   = cur_sum + i_rx_byte;
                            n_phase = PH_DST;
                        end
                    end
                    PH_DST: begin
                        if (i_rx_byte != i_own_address) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_sum   = cur_sum + i_rx_byte;
                            n_phase = PH_CLEN;
                        end
                    end
                    PH_CLEN: begin
                        n_clen  = i_rx_byte;
                        n_sum   = cur_sum + i_rx_byte;
                        n_phase = PH_PLEN;
                    end
                    PH_PLEN: begin
                        n_plen  = i_rx_byte;
                        n_sum   = cur_sum + i_rx_byte;
                        n_phase = PH_BODY;
                    end
                    PH_BODY: begin
                        if (cmd_left) begin
                            n_ccnt = cur_ccnt + 8'd1;
                            n_sum  = cur_sum + i_rx_byte;
                        end else if (param_left) begin
                            n_pcnt = cur_pcnt + 8'd1;
                            n_sum  = cur_sum + i_rx_byte;
                        end else if (i_rx_byte != cur_sum) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_TERM;
                        end
                    end
                    PH_TERM: begin
                        n_phase = PH_DONE;
                    end
                    default: begin
                        n_phase = PH_DONE;
                    end
                endcase
            end
        end
    end

    // Result produced by this byte, if any.
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '{kind: KIND_STATUS, payload_byte: 8'd0, payload_index: 8'd0,
                        status: ST_OK, frame_done: 1'b1};
        if (i_valid && cur_phase != PH_DONE) begin
            if (i_rx_byte == 8'd0) begin
                o_res_valid = 1'b1;
                o_res.status = ST_SHORT;
            end else begin
                case (cur_phase)
                    PH_SRC: begin
                        if (i_rx_byte != i_accepted_source) begin
                            o_res_valid  = 1'b1;
                            o_res.status = ST_SOURCE;
                        end
                    end
                    PH_DST: begin
                        if (i_rx_byte != i_own_address) begin
                            o_res_valid  = 1'b1;
                            o_res.status = ST_DEST;
                        end
                    end
                    PH_BODY: begin
                        if (cmd_left) begin
                            o_res_valid = 1'b1;
                            o_res = '{kind: KIND_CMD, payload_byte: i_rx_byte,
                                      payload_index: cur_ccnt, status: ST_OK,
                                      frame_done: 1'b0};
                        end else if (param_left) begin
                            o_res_valid = 1'b1;
                            o_res = '{kind: KIND_PARAM, payload_byte: i_rx_byte,
                                      payload_index: cur_pcnt, status: ST_OK,
                                      frame_done: 1'b0};
                        end else if (i_rx_byte != cur_sum) begin
                            o_res_valid  = 1'b1;
                            o_res.status = ST_CHECKSUM;
                        end
                    end
                    PH_TERM: begin
                        o_res_valid  = 1'b1;
                        o_res.status = (i_rx_byte == END_BYTE) ? ST_OK : ST_TERM;
                    end
                    default: begin
                        o_res_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_clen  <= 8'd0;
            r_plen  <= 8'd0;
            r_ccnt  <= 8'd0;
            r_pcnt  <= 8'd0;
            r_sum   <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_clen  <= n_clen;
            r_plen  <= n_plen;
            r_ccnt  <= n_ccnt;
            r_pcnt  <= n_pcnt;
            r_sum   <= n_sum;
        end
    end

endmodule

// ===== hw/rtl/afc_out_skid.sv =====
// Output register with a skid entry so input ready never waits on the sink.
module afc_out_skid
    import afc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_space,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready,
    output logic    o_skid_valid
);

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    out_free;

    assign out_free     = !r_out_valid || i_ready;
    assign o_space      = !r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_data       = r_out;
    assign o_skid_valid = r_skid_valid;

    // Control: the skid entry fills only when the output register is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid  <= r_skid_valid || i_push;
                r_skid_valid <= 1'b0;
            end else if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Payload: the oldest item moves forward first.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

// ===== hw/rtl/addressed_frame_checker_core.sv =====
// Results are registered in the output register, or the skid entry on a stall.
// Throughput: one byte per cycle while the skid entry is empty.
// A two-entry output stage keeps the slave side ready while one result is stalled.
// Reset (synchronous, active low) returns to start-byte hunting with counters,
// sum and both address registers cleared and the output stage empty.
module addressed_frame_checker_core
    import afc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration writes.
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // Received bytes.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] buffer_start
    // Results.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] payload_index,
                                        // [18:16] status, [23:19] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
    output logic        m_axis_tlast    // frame_done
);

    logic [7:0] r_accepted_source, r_own_address;
    logic       in_xfer;
    logic       res_valid;
    t_result    res, out_res;
    logic       skid_valid;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accepted_source <= 8'd0;
            r_own_address     <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SOURCE: r_accepted_source <= i_cfg_data;
                CFG_OWN:    r_own_address     <= i_cfg_data;
                default:    r_own_address     <= r_own_address;
            endcase
        end
    end

    assign in_xfer = s_axis_tvalid && s_axis_tready;

    afc_parser u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (in_xfer),
        .i_rx_byte         (s_axis_tdata),
        .i_buffer_start    (s_axis_tuser),
        .i_accepted_source (r_accepted_source),
        .i_own_address     (r_own_address),
        .o_res_valid       (res_valid),
        .o_res             (res)
    );

    afc_out_skid u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (res_valid),
        .i_data       (res),
        .o_space      (s_axis_tready),
        .o_valid      (m_axis_tvalid),
        .o_data       (out_res),
        .i_ready      (m_axis_tready),
        .o_skid_valid (skid_valid)
    );

    // Pack the result onto the master side.
    assign m_axis_tdata = {5'd0, out_res.status, out_res.payload_index, out_res.payload_byte};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.frame_done;

`ifndef NO_ASSERTIONS
    // The skid entry is only used behind a held output item.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        skid_valid |-> m_axis_tvalid)
        else $error("skid entry valid while output register empty");

    // Only status results close a frame.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == KIND_STATUS))
        else $error("frame_done on a payload result");

    // Payload results carry a zero status and never close a frame.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_STATUS)
            |-> (m_axis_tdata[18:16] == 3'd0 && !m_axis_tlast))
        else $error("payload result with status bits set");

    // A result pushed behind a stalled output must land in the skid entry.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready && res_valid && s_axis_tready) |=> skid_valid)
        else $error("result lost behind a stalled output");
`endif

endmodule
